### rtl/dtw_banded_distance_defines.svh
// Assertion macros shared by the RTL of dtw_banded_distance.
// Depends on the asserting module having i_clk and i_rst_n in scope.
`ifndef DTW_BANDED_DISTANCE_DEFINES_SVH
`define DTW_BANDED_DISTANCE_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define DTW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define DTW_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### rtl/dtw_pkg.sv
// Package for dtw_banded_distance: sizes, codes, shared types and helpers.
// No dependencies.
package dtw_pkg;

    localparam int MAX_LEN     = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int DIST_W    = 24;

    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);
    localparam int BAND_W = (CFG_W > LEN_W) ? CFG_W : LEN_W;
    localparam int HI_W   = BAND_W + 1;
    localparam int COST_W = 2 * (SAMPLE_BITS + 1);
    localparam int SUM_W  = ((ACC_BITS > COST_W) ? ACC_BITS : COST_W) + 1;
    localparam int RT_W   = (ACC_BITS + 1) / 2;
    localparam int RCNT_W = $clog2(RT_W + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ACC_BITS-1:0] INF      = {ACC_BITS{1'b1}};
    localparam logic [DIST_W-1:0]   DIST_MAX = {DIST_W{1'b1}};

    localparam logic FUNC_QUERY = 1'b0;
    localparam logic FUNC_CAND  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH  = 1'b1;

    typedef struct packed {
        logic                          is_cand;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [LEN_W-1:0]              clen;
    } t_item;

    typedef struct packed {
        logic                 we;
        logic [CFG_IDX_W-1:0] idx;
        logic [CFG_W-1:0]     data;
    } t_cfg_wr;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] n);
        logic [BAND_W-1:0] nw;
        nw = BAND_W'(n);
        if (nw > BAND_W'(MAX_LEN)) begin
            return LEN_W'(MAX_LEN);
        end
        return LEN_W'(nw);
    endfunction

endpackage

### rtl/dtw_stream_if.sv
// Valid/ready channel interfaces for the input and result streams.
// Depends on dtw_pkg.
interface dtw_in_if;
    import dtw_pkg::*;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [CFG_W-1:0]              cand_len;
    modport source(output valid, func, sample, cand_len, input ready);
    modport sink(input valid, func, sample, cand_len, output ready);
endinterface

interface dtw_out_if;
    import dtw_pkg::*;
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              no_path;
    modport source(output valid, distance, no_path, input ready);
    modport sink(input valid, distance, no_path, output ready);
endinterface

### rtl/dtw_banded_distance.sv
// Top level of the banded DTW distance block: front queue plus column engine.
// Depends on dtw_pkg, dtw_stream_if, dtw_front, dtw_back.
//
// Usage:
//   i_in carries requests: func 0 stores the next query sample, func 1 is the
//   next candidate sample with the candidate's length in cand_len.
//   o_out carries one result (distance, no_path) after a candidate's last sample.
//   Config: i_cfg_we/i_cfg_idx/i_cfg_data, index 0 query sample count (also
//   rewinds the query write pointer), index 1 band_width. Write only while idle.
// Timing:
//   A two-entry queue parts the input from the engine, so requests are taken
//   while the engine works. A query sample is written to the query RAM. A
//   candidate sample sweeps the query RAM and column RAM one cell a cycle
//   over the query length, MAX_LEN for a candidate's first sample, which also
//   resets the column. After the last sample the engine reads the corner cell,
//   runs the bit-serial square root (one root bit per cycle) and loads the
//   result register, skipping the root for an empty query or a saturated cost.
// Reset: synchronous; clears the queue, config, query write and candidate indexes.
// Stall: a pending result waits in the output register; the engine keeps
//   serving requests and only waits when a second result is ready.
module dtw_banded_distance (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dtw_in_if.sink                        i_in,
    dtw_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [dtw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dtw_pkg::CFG_W-1:0]     i_cfg_data
);
    import dtw_pkg::*;

    t_item   item;
    logic    item_valid;
    logic    item_pop;
    t_cfg_wr cfg;

    always_comb begin
        cfg.we   = i_cfg_we;
        cfg.idx  = i_cfg_idx;
        cfg.data = i_cfg_data;
    end

    dtw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_pop   (item_pop)
    );

    dtw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item       (item),
        .i_item_valid (item_valid),
        .o_item_pop   (item_pop),
        .o_out        (o_out)
    );
endmodule

### rtl/dtw_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module dtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/dtw_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on dtw_pkg and dtw_stream_if.
module dtw_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dtw_in_if.sink         i_in,
    output dtw_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_item_pop
);
    import dtw_pkg::*;

    t_item               r_buf [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wp;
    logic [QPTR_W-1:0]   r_rp;
    logic [QCNT_W-1:0]   r_cnt;
    logic                push;
    logic                pop;
    t_item               n_item;

    assign i_in.ready   = (r_cnt != QCNT_W'(QUEUE_DEPTH));
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_buf[r_rp];
    assign push         = i_in.valid && i_in.ready;
    assign pop          = i_item_pop && o_item_valid;

    always_comb begin
        n_item.is_cand = (i_in.func == FUNC_CAND);
        n_item.sample  = i_in.sample;
        n_item.clen    = clamp_len(i_in.cand_len);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= n_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (pop) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + QCNT_W'(1);
                2'b01:   r_cnt <= r_cnt - QCNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

### rtl/dtw_back.sv
// Back end: query store, banded column update engine, square root, result register.
// Depends on dtw_pkg, dtw_stream_if, dtw_ram and the assertion macro header.
`include "dtw_banded_distance_defines.svh"
module dtw_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dtw_pkg::t_cfg_wr i_cfg,
    input  dtw_pkg::t_item   i_item,
    input  logic             i_item_valid,
    output logic             o_item_pop,
    dtw_out_if.source        o_out
);
    import dtw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_BAND, S_RUN, S_DRAIN, S_FIN, S_READ, S_SQRT, S_OUT
    } t_state;

    t_state              r_state;
    logic [CFG_W-1:0]    r_query_count;
    logic [CFG_W-1:0]    r_band_width;
    logic [ADDR_W-1:0]   r_qwi;
    logic [LEN_W-1:0]    r_cand_index;
    logic [BAND_W-1:0]   r_eb;
    t_item               r_item;
    logic                r_first;
    logic [LEN_W-1:0]    r_j;
    logic [HI_W-1:0]     r_lo;
    logic [HI_W-1:0]     r_hi;
    logic [LEN_W-1:0]    r_n;
    logic [LEN_W-1:0]    r_k;

    logic                r_p1v;
    logic                r_p1_inb;
    logic [ADDR_W-1:0]   r_p1_addr;
    logic                r_p2v;
    logic                r_p2_inb;
    logic [ADDR_W-1:0]   r_p2_addr;
    logic [COST_W-1:0]   r_cost;
    logic [ACC_BITS-1:0] r_old;
    logic [ACC_BITS-1:0] r_left;
    logic [ACC_BITS-1:0] r_diag;

    logic [2*RT_W-1:0]   r_sv;
    logic [RT_W+1:0]     r_rem;
    logic [RT_W-1:0]     r_root;
    logic [RCNT_W-1:0]   r_rcnt;
    logic                r_sat;

    logic                r_ovalid;
    logic [DIST_W-1:0]   r_odist;
    logic                r_onp;

    logic [LEN_W-1:0]    qlen;
    logic [ADDR_W-1:0]   qlen_m1;
    logic [BAND_W-1:0]   qlen_w;
    logic [BAND_W-1:0]   clen_w;
    logic [BAND_W-1:0]   len_diff;
    logic [BAND_W-1:0]   n_eb;
    logic [HI_W-1:0]     j_w;
    logic [HI_W-1:0]     eb_w;
    logic [HI_W-1:0]     hi_raw;
    logic [HI_W-1:0]     n_lo;
    logic [HI_W-1:0]     n_hi;
    logic [LEN_W-1:0]    n_n;
    logic [HI_W-1:0]     cell_i;
    logic                n_inb;

    logic [SAMPLE_BITS-1:0]       q_rdata;
    logic [ACC_BITS-1:0]          c_rdata;
    logic signed [SAMPLE_BITS:0]  dd;
    logic [SAMPLE_BITS:0]         dd_abs;
    logic [COST_W-1:0]            n_cost;
    logic [ACC_BITS-1:0]          n_old;
    logic [ACC_BITS-1:0]          m_min;
    logic [SUM_W-1:0]             sum;
    logic [ACC_BITS-1:0]          n_nv;
    logic                         q_we;
    logic [ADDR_W-1:0]            c_raddr;

    logic [RT_W+1:0]              rem_sh;
    logic [RT_W+1:0]              trial;
    logic                         rt_ge;
    logic [RT_W+DIST_W-1:0]       root_w;
    logic [DIST_W-1:0]            n_dist;

    // lengths and band
    always_comb begin
        qlen    = clamp_len(r_query_count);
        qlen_m1 = ADDR_W'(qlen - LEN_W'(1));
        qlen_w  = BAND_W'(qlen);
        clen_w  = BAND_W'(r_item.clen);
        len_diff = (qlen_w > clen_w) ? (qlen_w - clen_w) : (clen_w - qlen_w);
        n_eb = BAND_W'(r_band_width);
        if (n_eb == '0) begin
            n_eb = (qlen_w > clen_w) ? qlen_w : clen_w;
        end
        if (n_eb < len_diff) begin
            n_eb = len_diff;
        end
        j_w    = HI_W'(r_j);
        eb_w   = HI_W'(r_eb);
        n_lo   = (j_w > eb_w) ? (j_w - eb_w) : HI_W'(1);
        hi_raw = j_w + eb_w;
        n_hi   = (hi_raw > HI_W'(qlen)) ? HI_W'(qlen) : hi_raw;
        n_n    = r_first ? LEN_W'(MAX_LEN) : qlen;
        cell_i = HI_W'(r_k) + HI_W'(1);
        n_inb  = (cell_i >= r_lo) && (cell_i <= r_hi);
    end

    // cell stage 1: cost from RAM data
    always_comb begin
        dd     = $signed({q_rdata[SAMPLE_BITS-1], q_rdata})
               - $signed({r_item.sample[SAMPLE_BITS-1], r_item.sample});
        dd_abs = dd[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-dd) : (SAMPLE_BITS+1)'(dd);
        n_cost = COST_W'(dd_abs) * COST_W'(dd_abs);
        n_old  = r_first ? INF : c_rdata;
    end

    // cell stage 2: min of neighbors plus cost, saturating
    always_comb begin
        m_min = r_old;
        if (r_left < m_min) begin
            m_min = r_left;
        end
        if (r_diag < m_min) begin
            m_min = r_diag;
        end
        sum  = SUM_W'(m_min) + SUM_W'(r_cost);
        n_nv = (!r_p2_inb || (sum >= SUM_W'(INF))) ? INF : ACC_BITS'(sum);
    end

    // one root bit per cycle
    always_comb begin
        rem_sh = {r_rem[RT_W-1:0], r_sv[2*RT_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        rt_ge  = (rem_sh >= trial);
        root_w = (RT_W+DIST_W)'(r_root);
        n_dist = (root_w > (RT_W+DIST_W)'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_w);
    end

    assign q_we       = (r_state == S_IDLE) && i_item_valid && !i_item.is_cand;
    assign c_raddr    = (r_state == S_FIN) ? qlen_m1 : r_k[ADDR_W-1:0];
    assign o_item_pop = (r_state == S_IDLE) && i_item_valid;

    dtw_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_LEN)) u_query_ram (
        .i_clk   (i_clk),
        .i_we    (q_we),
        .i_waddr (r_qwi),
        .i_wdata (SAMPLE_BITS'(i_item.sample)),
        .i_raddr (r_k[ADDR_W-1:0]),
        .o_rdata (q_rdata)
    );

    dtw_ram #(.WIDTH(ACC_BITS), .DEPTH(MAX_LEN)) u_column_ram (
        .i_clk   (i_clk),
        .i_we    (r_p2v),
        .i_waddr (r_p2_addr),
        .i_wdata (n_nv),
        .i_raddr (c_raddr),
        .o_rdata (c_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_query_count <= '0;
            r_band_width  <= '0;
            r_qwi         <= '0;
            r_cand_index  <= '0;
            r_eb          <= '0;
            r_p1v         <= 1'b0;
            r_p2v         <= 1'b0;
            r_ovalid      <= 1'b0;
        end else begin
            r_p1v     <= (r_state == S_RUN);
            r_p2v     <= r_p1v;
            r_p2_inb  <= r_p1_inb;
            r_p2_addr <= r_p1_addr;
            r_cost    <= n_cost;
            r_old     <= n_old;
            if (r_p2v) begin
                r_left <= n_nv;
                r_diag <= r_old;
            end
            // S_OUT reloads the result register itself
            if (o_out.ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        if (i_item.is_cand) begin
                            r_item  <= i_item;
                            r_state <= S_SETUP;
                        end else begin
                            r_qwi <= r_qwi + ADDR_W'(1);
                        end
                    end
                end
                S_SETUP: begin
                    r_first <= (r_cand_index == '0);
                    r_j     <= r_cand_index + LEN_W'(1);
                    if (r_cand_index == '0) begin
                        r_eb <= n_eb;
                    end
                    r_state <= S_BAND;
                end
                S_BAND: begin
                    r_lo    <= n_lo;
                    r_hi    <= n_hi;
                    r_n     <= n_n;
                    r_k     <= '0;
                    r_left  <= INF;
                    r_diag  <= r_first ? '0 : INF;
                    r_state <= (n_n == '0) ? S_FIN : S_RUN;
                end
                S_RUN: begin
                    r_p1_inb  <= n_inb;
                    r_p1_addr <= r_k[ADDR_W-1:0];
                    r_k       <= r_k + LEN_W'(1);
                    if (r_k == r_n - LEN_W'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1v && !r_p2v) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_j < r_item.clen) begin
                        r_cand_index <= r_j;
                        r_state      <= S_IDLE;
                    end else begin
                        r_cand_index <= '0;
                        if (qlen == '0) begin
                            r_sat   <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_rem  <= '0;
                    r_root <= '0;
                    r_rcnt <= RCNT_W'(RT_W);
                    r_sv   <= (2*RT_W)'(c_rdata);
                    if (c_rdata == INF) begin
                        r_sat   <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_sat   <= 1'b0;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sv   <= {r_sv[2*RT_W-3:0], 2'b00};
                    r_rem  <= rt_ge ? (rem_sh - trial) : rem_sh;
                    r_root <= {r_root[RT_W-2:0], rt_ge};
                    r_rcnt <= r_rcnt - RCNT_W'(1);
                    if (r_rcnt == RCNT_W'(1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid <= 1'b1;
                        r_odist  <= r_sat ? DIST_MAX : n_dist;
                        r_onp    <= r_sat;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (i_cfg.we) begin
                case (i_cfg.idx)
                    CFG_QUERY_COUNT: begin
                        r_query_count <= i_cfg.data;
                        r_qwi         <= '0;
                    end
                    CFG_BAND_WIDTH: r_band_width <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.distance = r_odist;
    assign o_out.no_path  = r_onp;

    `DTW_ASSERT(a_col_write_in_run, r_p2v |-> (r_state == S_RUN || r_state == S_DRAIN), "column write outside a sweep")
    `DTW_ASSERT(a_result_from_out, $rose(r_ovalid) |-> ($past(r_state) == S_OUT), "result raised outside output step")
    `DTW_ASSERT(a_issue_in_range, (r_state == S_RUN) |-> (r_k < r_n), "cell index past sweep end")
    `DTW_ASSERT_NEXT(a_end_clears_index, (r_state == S_FIN) && (r_j >= r_item.clen), r_cand_index == '0, "candidate index not cleared at end")
endmodule
